// ===== rtl/core/kkc_pkg.sv =====
// Shared types, constants and the coefficient table for the keystream cipher.
// No dependencies; imported by kkc_front, kkc_back and the top level.
`default_nettype none

package kkc_pkg;

   localparam logic [31:0] KEY_MUL   = 32'd28454642;
   localparam logic [31:0] CURR_MUL  = 32'd38745674;
   localparam logic [31:0] KEY_RESET = 32'd1363;
   localparam logic [31:0] MULT_RESET =
      32'(64'(KEY_RESET) * 64'(KEY_MUL) + 64'(CURR_MUL) + 64'd1);

   localparam logic [3:0] POS_LAST = 4'd9;

   localparam logic [1:0] OP_ENC = 2'd0;
   localparam logic [1:0] OP_DEC = 2'd1;

   typedef enum logic [1:0] {
      CLS_ENC,
      CLS_DEC,
      CLS_PASS
   } cls_type;

   typedef struct packed {
      cls_type    op_class;
      logic [7:0] data;
      logic       last;
   } entry_type;

   function automatic logic [10:0] coef_of(input logic [3:0] pos);
      logic [10:0] c;
      case (pos)
         4'd1:    c = 11'd150;
         4'd2:    c = 11'd1020;
         4'd3:    c = 11'd800;
         4'd4:    c = 11'd330;
         4'd5:    c = 11'd1440;
         4'd6:    c = 11'd910;
         4'd7:    c = 11'd1080;
         4'd8:    c = 11'd240;
         4'd9:    c = 11'd760;
         default: c = 11'd500;
      endcase
      return c;
   endfunction

   // 2^8 == 1 mod 255: fold bytes, then one conditional subtract
   function automatic logic [7:0] mod255(input logic [31:0] v);
      logic [9:0] s1;
      logic [8:0] s2;
      s1 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
      s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
      if (s2 >= 9'd255) begin
         s2 = s2 - 9'd255;
      end
      return s2[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/keyed_keystream_cipher_checksum_unit.sv =====
// Keyed keystream cipher with running checksum: one result beat per request beat.
// A beat passes the back end sequence: take, generator multiply, mod 255, sum.
// No new beat is taken before the last commits, which an output stall can hold.
// A queue of QUEUE_DEPTH entries accepts requests while the back end works.
// Synchronous reset: key 1363, generator reloaded, position and checksum cleared.
// Depends on kkc_pkg, kkc_front and kkc_back.
`default_nettype none

module keyed_keystream_cipher_checksum_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [1:0]   req_opcode,
   input  wire  [7:0]   req_data_in,
   input  wire          req_last_byte,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [7:0]   rsp_data_out,
   output logic [31:0]  rsp_running_sum,
   output logic         rsp_is_last,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [31:0]  csr_cipher_key
);
   import kkc_pkg::*;

   logic      q_valid;
   logic      q_take;
   entry_type q_head;

   kkc_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_data_in   (req_data_in),
      .req_last_byte (req_last_byte),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_take        (q_take)
   );

   kkc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_take          (q_take),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cipher_key  (csr_cipher_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_running_sum (rsp_running_sum),
      .rsp_is_last     (rsp_is_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/kkc_front.sv =====
// Front end: accepts request beats, classifies the opcode, queues entries.
// Depends on kkc_pkg.
`default_nettype none

module kkc_front #(
   parameter int DEPTH = 2
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [1:0]              req_opcode,
   input  wire  [7:0]              req_data_in,
   input  wire                     req_last_byte,
   output logic                    q_valid,
   output kkc_pkg::entry_type      q_head,
   input  wire                     q_take
);
   import kkc_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push;
   logic            pop;
   entry_type       new_entry;

   assign req_stall = (count_ff == CW'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (count_ff != '0);
   assign q_head    = mem_ff[rd_ptr_ff];

   always_comb begin
      case (req_opcode)
         OP_ENC:  new_entry.op_class = CLS_ENC;
         OP_DEC:  new_entry.op_class = CLS_DEC;
         default: new_entry.op_class = CLS_PASS;
      endcase
      new_entry.data = req_data_in;
      new_entry.last = req_last_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count over depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// ===== rtl/core/kkc_back.sv =====
// Back end: key register, keystream generator, checksum and result register.
// Depends on kkc_pkg; fed by kkc_front.
`default_nettype none

module kkc_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   input  kkc_pkg::entry_type  q_head,
   output logic                q_take,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [31:0]         csr_cipher_key,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [7:0]          rsp_data_out,
   output logic [31:0]         rsp_running_sum,
   output logic                rsp_is_last
);
   import kkc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_SUM  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] key_ff;
   logic [31:0] mult_ff;
   logic [31:0] gen_ff;
   logic [3:0]  pos_ff;
   logic [31:0] sum_ff;
   entry_type   item_ff;
   logic [7:0]  g_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic [31:0] rsp_sum_ff;
   logic        rsp_last_ff;

   logic        csr_write;
   logic [31:0] key_prod;
   logic [31:0] gen_prod;
   logic [18:0] k;
   logic [7:0]  result;
   logic [31:0] sum_calc;
   logic [3:0]  pos_next;
   logic        out_free;
   logic        commit;

   assign csr_ready = (state_ff == S_IDLE) && !q_valid;
   assign csr_write = csr_valid && csr_ready;
   assign q_take    = (state_ff == S_IDLE) && q_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_SUM) && out_free;

   assign key_prod = csr_cipher_key * KEY_MUL;
   assign gen_prod = gen_ff * mult_ff;
   assign k        = 19'(g_ff) * 19'(coef_of(pos_ff));
   assign sum_calc = sum_ff + {{24{item_ff.data[7]}}, item_ff.data} + 32'(k);
   assign pos_next = (pos_ff >= POS_LAST) ? 4'd0 : pos_ff + 4'd1;

   always_comb begin
      case (item_ff.op_class)
         CLS_ENC: result = item_ff.data + k[7:0];
         CLS_DEC: result = item_ff.data - k[7:0];
         default: result = item_ff.data;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_valid) state_in = S_MUL;
         S_MUL:   state_in = S_MOD;
         S_MOD:   state_in = S_SUM;
         S_SUM:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_ff       <= KEY_RESET;
         mult_ff      <= MULT_RESET;
         gen_ff       <= KEY_RESET;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            key_ff  <= csr_cipher_key;
            mult_ff <= key_prod + CURR_MUL + 32'd1;
            gen_ff  <= csr_cipher_key;
            pos_ff  <= '0;
            sum_ff  <= '0;
         end
         if (state_ff == S_MUL) begin
            gen_ff <= gen_prod;
         end
         if (commit) begin
            if (item_ff.last) begin
               gen_ff <= key_ff;
               pos_ff <= '0;
               sum_ff <= '0;
            end else begin
               pos_ff <= pos_next;
               sum_ff <= sum_calc;
            end
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         item_ff <= q_head;
      end
      if (state_ff == S_MOD) begin
         g_ff <= mod255(gen_ff);
      end
      if (commit) begin
         rsp_data_ff <= result;
         rsp_sum_ff  <= sum_calc;
         rsp_last_ff <= item_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_running_sum = rsp_sum_ff;
   assign rsp_is_last     = rsp_last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("position out of range");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed beat not presented");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> pos_ff == 4'd0 && sum_ff == 32'd0 && gen_ff == key_ff)
      else $error("key write did not restart message");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      commit && item_ff.last |=> pos_ff == 4'd0 && sum_ff == 32'd0)
      else $error("last beat did not restart message");

endmodule

`default_nettype wire
